>>> sv/random_replacement_policy_top_assert.svh
// ----------------------------------------------------------------------------
// random replacement policy assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RANDOM_REPLACEMENT_POLICY_TOP_ASSERT_SVH
`define RANDOM_REPLACEMENT_POLICY_TOP_ASSERT_SVH

// same-cycle implication
`define RRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// types, codes and helpers shared by the random replacement policy block
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int ENTRIES   = 256;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int ID_W      = 64;
  localparam int SIZE_W    = 32;
  localparam int LIMIT_W   = 40;
  localparam int LFSR_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int PROD_W    = LFSR_W + CNT_W;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HIT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   obj_id;
    logic [SIZE_W-1:0] obj_bytes;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]     evict_id;
    logic                victim_valid;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    occupancy;
  } out_t;

  typedef struct packed {
    logic                accept;
    logic                lfsr_step;
    logic                scan_clear;
    logic                scan_run;
    logic                mul_load;
    logic                rd_slot;
    logic                slot_from_match;
    logic                rd_last;
    logic                victim_cap;
    logic                wr_insert;
    logic                wr_move;
    logic                finish;
    logic [STATUS_W-1:0] status;
    logic                victim_valid;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             too_large;
    logic             cnt_zero;
    logic             cnt_full;
    logic             match_hit;
    logic             scan_done;
  } sts_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] sh;
    sh = s >> 1;
    return s[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

>>> sv/rrp_ram.sv
// ----------------------------------------------------------------------------
// rrp_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module rrp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rrp_ctrl.sv
// ----------------------------------------------------------------------------
// rrp_ctrl
// request sequencer: decode, id scan, victim pick and slot compaction
// ----------------------------------------------------------------------------
module rrp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rrp_pkg::sts_t sts,
  output rrp_pkg::ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_SCAN    = 8'b0000_0100,
    S_MUL     = 8'b0000_1000,
    S_RD_SLOT = 8'b0001_0000,
    S_RD_LAST = 8'b0010_0000,
    S_WR_MOVE = 8'b0100_0000,
    S_SPARE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          rrp_pkg::CMD_INSERT: begin
            if (sts.too_large) begin
              ctl.finish = 1'b1;
              ctl.status = rrp_pkg::ST_TOO_LARGE;
              state_nxt  = S_IDLE;
            end else begin
              ctl.scan_clear = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          rrp_pkg::CMD_HIT: begin
            ctl.finish = 1'b1;
            ctl.status = rrp_pkg::ST_DONE;
            state_nxt  = S_IDLE;
          end
          rrp_pkg::CMD_EVICT: begin
            if (sts.cnt_zero) begin
              ctl.finish = 1'b1;
              ctl.status = rrp_pkg::ST_EMPTY;
              state_nxt  = S_IDLE;
            end else begin
              ctl.lfsr_step = 1'b1;
              state_nxt     = S_MUL;
            end
          end
          rrp_pkg::CMD_REMOVE: begin
            ctl.scan_clear = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.match_hit) begin
          if (sts.cmd == rrp_pkg::CMD_INSERT) begin
            ctl.finish = 1'b1;
            ctl.status = rrp_pkg::ST_PRESENT;
            state_nxt  = S_IDLE;
          end else begin
            ctl.slot_from_match = 1'b1;
            state_nxt           = S_RD_LAST;
          end
        end else if (sts.scan_done) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.cmd == rrp_pkg::CMD_INSERT) begin
            if (sts.cnt_full) begin
              ctl.status = rrp_pkg::ST_FULL;
            end else begin
              ctl.wr_insert = 1'b1;
              ctl.status    = rrp_pkg::ST_DONE;
            end
          end else begin
            ctl.status = rrp_pkg::ST_NOT_FOUND;
          end
        end else begin
          ctl.scan_run = 1'b1;
        end
      end
      S_MUL: begin
        ctl.mul_load = 1'b1;
        state_nxt    = S_RD_SLOT;
      end
      S_RD_SLOT: begin
        ctl.rd_slot = 1'b1;
        state_nxt   = S_RD_LAST;
      end
      S_RD_LAST: begin
        ctl.rd_last    = 1'b1;
        ctl.victim_cap = (sts.cmd == rrp_pkg::CMD_EVICT);
        state_nxt      = S_WR_MOVE;
      end
      S_WR_MOVE: begin
        ctl.wr_move      = 1'b1;
        ctl.finish       = 1'b1;
        ctl.status       = rrp_pkg::ST_DONE;
        ctl.victim_valid = (sts.cmd == rrp_pkg::CMD_EVICT);
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rrp_datapath.sv
// ----------------------------------------------------------------------------
// rrp_datapath
// id store, resident count, victim lfsr, config registers and result register
// ----------------------------------------------------------------------------
module rrp_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rrp_pkg::in_t                     in_req,
  input  logic                             cfg_we,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  rrp_pkg::ctl_t                    ctl,
  output rrp_pkg::sts_t                    sts,
  output logic                             out_valid,
  output rrp_pkg::out_t                    out_rsp
);

  rrp_pkg::in_t                      req_r, req_nxt;
  logic [rrp_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [rrp_pkg::LFSR_W-1:0]        lfsr_r, lfsr_nxt;
  logic [rrp_pkg::LIMIT_W-1:0]       limit_r, limit_nxt;
  logic [rrp_pkg::CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                              cmp_vld_r, cmp_vld_nxt;
  logic [rrp_pkg::IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [rrp_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic [rrp_pkg::IDX_W-1:0]         slot_r, slot_nxt;
  logic [rrp_pkg::ID_W-1:0]          victim_r, victim_nxt;
  rrp_pkg::out_t                     out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic                              ram_we;
  logic [rrp_pkg::IDX_W-1:0]         ram_waddr;
  logic [rrp_pkg::ID_W-1:0]          ram_wdata;
  logic [rrp_pkg::IDX_W-1:0]         ram_raddr;
  logic [rrp_pkg::ID_W-1:0]          ram_rdata;

  logic [rrp_pkg::CNT_W-1:0]         cnt_dec;
  logic [rrp_pkg::IDX_W-1:0]         tail_idx;
  logic [rrp_pkg::CNT_W-1:0]         prod_hi;
  logic [rrp_pkg::IDX_W-1:0]         mul_idx;
  logic                              scan_more;

  rrp_ram #(
    .WIDTH (rrp_pkg::ID_W),
    .DEPTH (rrp_pkg::ENTRIES)
  ) u_id_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_dec   = cnt_r - rrp_pkg::CNT_W'(1);
  assign tail_idx  = cnt_dec[rrp_pkg::IDX_W-1:0];
  assign prod_hi   = prod_r[rrp_pkg::LFSR_W +: rrp_pkg::CNT_W];
  assign mul_idx   = (prod_hi >= cnt_r) ? tail_idx : prod_hi[rrp_pkg::IDX_W-1:0];
  assign scan_more = (scan_idx_r < cnt_r);

  assign sts.cmd       = req_r.command;
  assign sts.too_large = (rrp_pkg::LIMIT_W'(req_r.obj_bytes) > limit_r);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.cnt_full  = (cnt_r >= rrp_pkg::CNT_W'(rrp_pkg::ENTRIES));
  assign sts.match_hit = cmp_vld_r && (ram_rdata == req_r.obj_id);
  assign sts.scan_done = !cmp_vld_r && !scan_more;

  // memory ports
  always_comb begin
    ram_raddr = scan_idx_r[rrp_pkg::IDX_W-1:0];
    if (ctl.rd_slot) begin
      ram_raddr = mul_idx;
    end else if (ctl.rd_last) begin
      ram_raddr = tail_idx;
    end
    ram_we    = ctl.wr_insert || ctl.wr_move;
    ram_waddr = ctl.wr_insert ? cnt_r[rrp_pkg::IDX_W-1:0] : slot_r;
    ram_wdata = ctl.wr_insert ? req_r.obj_id : ram_rdata;
  end

  always_comb begin
    req_nxt       = ctl.accept ? in_req : req_r;
    cnt_nxt       = cnt_r;
    lfsr_nxt      = lfsr_r;
    limit_nxt     = limit_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    prod_nxt      = prod_r;
    slot_nxt      = slot_r;
    victim_nxt    = victim_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        rrp_pkg::CFG_BYTE_LIMIT: begin
          limit_nxt = cfg_wdata[rrp_pkg::LIMIT_W-1:0];
        end
        rrp_pkg::CFG_RANDOM_SEED: begin
          lfsr_nxt = (cfg_wdata[rrp_pkg::LFSR_W-1:0] == '0) ? rrp_pkg::LFSR_ONE
                                                          : cfg_wdata[rrp_pkg::LFSR_W-1:0];
        end
        default: begin
          limit_nxt = limit_r;
        end
      endcase
    end else if (ctl.lfsr_step) begin
      lfsr_nxt = rrp_pkg::lfsr_next(lfsr_r);
    end

    if (ctl.scan_clear) begin
      scan_idx_nxt = '0;
      cmp_vld_nxt  = 1'b0;
    end else if (ctl.scan_run) begin
      cmp_vld_nxt = scan_more;
      cmp_idx_nxt = scan_idx_r[rrp_pkg::IDX_W-1:0];
      if (scan_more) begin
        scan_idx_nxt = scan_idx_r + rrp_pkg::CNT_W'(1);
      end
    end

    if (ctl.mul_load) begin
      prod_nxt = rrp_pkg::PROD_W'(lfsr_r) * rrp_pkg::PROD_W'(cnt_r);
    end

    if (ctl.rd_slot) begin
      slot_nxt = mul_idx;
    end else if (ctl.slot_from_match) begin
      slot_nxt = cmp_idx_r;
    end

    if (ctl.victim_cap) begin
      victim_nxt = ram_rdata;
    end

    if (ctl.wr_insert) begin
      cnt_nxt = cnt_r + rrp_pkg::CNT_W'(1);
    end else if (ctl.wr_move) begin
      cnt_nxt = cnt_dec;
    end

    if (ctl.finish) begin
      out_valid_nxt        = 1'b1;
      out_nxt.evict_id     = ctl.victim_valid ? victim_r : '0;
      out_nxt.victim_valid = ctl.victim_valid;
      out_nxt.status       = ctl.status;
      out_nxt.occupancy    = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lfsr_r      <= rrp_pkg::LFSR_ONE;
      limit_r     <= '1;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      lfsr_r      <= lfsr_nxt;
      limit_r     <= limit_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    prod_r     <= prod_nxt;
    slot_r     <= slot_nxt;
    victim_r   <= victim_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

>>> sv/random_replacement_policy_top.sv
// ----------------------------------------------------------------------------
// random_replacement_policy_top
// Random replacement cache policy over a dense list of resident object ids.
//
// A request (command, obj_id, obj_bytes on in_req) is taken at a clock edge
// with start high and busy low. Exactly one result comes back on out_rsp,
// marked by out_valid for a single cycle; the receiver cannot stall it.
// Configuration (byte limit, LFSR seed) is written through cfg_we, cfg_index
// and cfg_wdata while idle: a rule for the user, not enforced by the block.
// A seed write loads the LFSR at once. Steps to out_valid, n ids resident:
//   hit, refused oversize insert, evict of an empty store: decode only
//   evict: lfsr step, multiply, slot read, last read, write back
//   insert: scan of up to n ids; remove: scan, last read, write back
// The id match is a scan through the single read port of the id store, one
// entry per cycle, which sets insert and remove latency. One request is in
// flight at a time; a new one may be taken in the cycle its result shows.
// Reset (rst_n low, synchronous) empties the store, loads the LFSR with 1
// and sets the byte limit to all ones; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "random_replacement_policy_top_assert.svh"

module random_replacement_policy_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rrp_pkg::in_t                   in_req,
  output logic                           out_valid,
  output rrp_pkg::out_t                  out_rsp,
  input  logic                           cfg_we,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rrp_pkg::ctl_t ctl;
  rrp_pkg::sts_t sts;

  rrp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  rrp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  `RRP_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request not taken")
  `RRP_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy),
                  "result without a request in flight")
  `RRP_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy,
                  "result shown while sequencer still busy")
  `RRP_ASSERT_IMP(a_victim_done, clk, rst_n, out_valid && out_rsp.victim_valid,
                  out_rsp.status == rrp_pkg::ST_DONE, "victim with error status")

endmodule
